/* src/led_matrix_frame_buffer_refresh_defines.svh */
// Assertion macros for the LED matrix frame buffer checker.
// Used by the checker file only; relies on i_clk and i_rst_n in scope.
`ifndef LED_MATRIX_FRAME_BUFFER_REFRESH_DEFINES_SVH
`define LED_MATRIX_FRAME_BUFFER_REFRESH_DEFINES_SVH

// Checked only outside reset
`define LMFB_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define LMFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/lmfb_pkg.sv */
// Shared types, constants and helpers for the LED matrix frame buffer.
// No dependencies.
`default_nettype none

package lmfb_pkg;

    localparam int ROWS_DEF    = 8;
    localparam int MODULES_DEF = 4;
    localparam int COLS        = 32;
    localparam int CMD_W       = 3;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 5;
    localparam int SHIFT_W     = 7;
    localparam int WORD_W      = 16;
    localparam int BRIGHT_W    = 4;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 4'hF;

    // Driver control words
    localparam logic [WORD_W-1:0] WORD_SHUTDOWN    = 16'h0C00;
    localparam logic [WORD_W-1:0] WORD_WAKE        = 16'h0C01;
    localparam logic [WORD_W-1:0] WORD_DECODE_OFF  = 16'h0900;
    localparam logic [WORD_W-1:0] WORD_SCAN_ALL    = 16'h0B07;
    localparam logic [WORD_W-1:0] WORD_BRIGHT_BASE = 16'h0A00;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 3'd0,
        CMD_READ    = 3'd1,
        CMD_SCROLL  = 3'd2,
        CMD_SETBIT  = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_REFRESH = 3'd5,
        CMD_INIT    = 3'd6,
        CMD_NONE    = 3'd7
    } t_cmd;

    // Word sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SHUT,
        SEQ_DECODE,
        SEQ_SCAN,
        SEQ_BRIGHT,
        SEQ_ROWS,
        SEQ_WAKE
    } t_seq;

    // Classified request as queued between front and back
    typedef struct packed {
        t_cmd              op;
        logic [ROW_W-1:0]  row;
        logic              row_ok;
        logic [COL_W-1:0]  col;
        logic              bit_value;
        logic              sh_neg;
        logic              sh_clr;
        logic [COL_W-1:0]  sh_amt;
        logic [COLS-1:0]   row_data;
    } t_req;

    // One result item
    typedef struct packed {
        logic [WORD_W-1:0] spi_word;
        logic              is_spi_word;
        logic [COLS-1:0]   read_data;
        logic              error;
        logic              last;
    } t_res;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/lmfb_fifo.sv */
// Two-entry queue used between front and back and on the result side.
// No package dependency.
`default_nettype none

module lmfb_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_wdata;
    end

endmodule

`default_nettype wire

/* src/lmfb_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on lmfb_pkg and lmfb_fifo.
`default_nettype none

module lmfb_front #(
    parameter int ROWS = lmfb_pkg::ROWS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    input  wire logic        [lmfb_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic        [lmfb_pkg::ROW_W-1:0]   i_row,
    input  wire logic        [lmfb_pkg::COL_W-1:0]   i_col,
    input  wire logic                               i_bit_value,
    input  wire logic signed [lmfb_pkg::SHIFT_W-1:0] i_shift_amount,
    input  wire logic        [lmfb_pkg::COLS-1:0]    i_row_data,
    output logic                                    o_full,
    input  wire logic                               i_req_pop,
    output lmfb_pkg::t_req                          o_req,
    output logic                                    o_req_valid
);

    lmfb_pkg::t_req                   req;
    logic [lmfb_pkg::SHIFT_W-1:0]     s_raw;
    logic [lmfb_pkg::SHIFT_W-1:0]     s_mag;
    logic                             q_empty;

    // classify: row range and scroll direction and magnitude
    always_comb begin
        s_raw         = $unsigned(i_shift_amount);
        s_mag         = s_raw[lmfb_pkg::SHIFT_W-1] ? (lmfb_pkg::SHIFT_W'(0) - s_raw) : s_raw;
        req.op        = lmfb_pkg::t_cmd'(i_cmd);
        req.row       = i_row;
        req.row_ok    = {1'b0, i_row} < (lmfb_pkg::ROW_W+1)'(ROWS);
        req.col       = i_col;
        req.bit_value = i_bit_value;
        req.sh_neg    = s_raw[lmfb_pkg::SHIFT_W-1];
        req.sh_clr    = s_mag[lmfb_pkg::SHIFT_W-1] | s_mag[lmfb_pkg::SHIFT_W-2];
        req.sh_amt    = s_mag[lmfb_pkg::COL_W-1:0];
        req.row_data  = i_row_data;
    end

    lmfb_fifo #(
        .WIDTH ($bits(lmfb_pkg::t_req))
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (req),
        .i_pop   (i_req_pop),
        .o_rdata (o_req),
        .o_full  (o_full),
        .o_empty (q_empty)
    );

    assign o_req_valid = !q_empty;

endmodule

`default_nettype wire

/* src/lmfb_back.sv */
// Back end: frame buffer, buffer command execution and driver word sequencer.
// Depends on lmfb_pkg and lmfb_fifo; feeds the result queue.
`default_nettype none

module lmfb_back #(
    parameter int ROWS    = lmfb_pkg::ROWS_DEF,
    parameter int MODULES = lmfb_pkg::MODULES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [lmfb_pkg::BRIGHT_W-1:0]   i_cfg_wr_data,
    input  wire lmfb_pkg::t_req                  i_req,
    input  wire logic                            i_req_valid,
    output logic                                 o_req_pop,
    input  wire logic                            i_res_pop,
    output lmfb_pkg::t_res                       o_res,
    output logic                                 o_res_empty
);

    localparam int ROW_CW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MOD_CW = (MODULES > 1) ? $clog2(MODULES) : 1;

    logic [lmfb_pkg::COLS-1:0]     r_frame [ROWS];
    logic [lmfb_pkg::BRIGHT_W-1:0] r_brightness;
    lmfb_pkg::t_seq                r_state;
    lmfb_pkg::t_seq                n_state;
    logic [ROW_CW-1:0]             r_row_cnt;
    logic [MOD_CW-1:0]             r_mod_cnt;
    logic                          r_is_init;

    logic                          out_full;
    logic                          out_room;
    logic                          out_push;
    lmfb_pkg::t_res                out_res;
    logic                          mod_last;
    logic                          row_last;
    logic                          exec;
    logic                          clr_all;
    logic [ROW_CW-1:0]             rd_idx;
    logic [lmfb_pkg::COLS-1:0]     rd_row;
    logic [2*lmfb_pkg::COLS-1:0]   rd_ext;
    logic [5:0]                    byte_sel;
    logic [7:0]                    mod_byte;
    logic [7:0]                    row_addr;
    logic [lmfb_pkg::WORD_W-1:0]   row_word;

    assign out_room = !out_full;
    assign mod_last = r_mod_cnt == MOD_CW'(MODULES - 1);
    assign row_last = r_row_cnt == ROW_CW'(ROWS - 1);

    // single read port: sequencer row during a refresh, else the request row
    assign rd_idx   = (r_state == lmfb_pkg::SEQ_ROWS) ? r_row_cnt : i_req.row[ROW_CW-1:0];
    assign rd_row   = r_frame[rd_idx];
    assign rd_ext   = {{lmfb_pkg::COLS{1'b0}}, rd_row};
    assign byte_sel = 6'({r_mod_cnt, 3'b000});
    assign mod_byte = rd_ext[byte_sel +: 8];
    assign row_addr = 8'(ROWS) - 8'(r_row_cnt);
    assign row_word = {row_addr, lmfb_pkg::rev8(mod_byte)};

    // brightness register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= lmfb_pkg::BRIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_brightness <= i_cfg_wr_data;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmfb_pkg::SEQ_IDLE: begin
                if (i_req_valid && out_room) begin
                    if (i_req.op == lmfb_pkg::CMD_REFRESH)   n_state = lmfb_pkg::SEQ_ROWS;
                    else if (i_req.op == lmfb_pkg::CMD_INIT) n_state = lmfb_pkg::SEQ_SHUT;
                end
            end
            lmfb_pkg::SEQ_SHUT: begin
                if (out_room && mod_last) n_state = lmfb_pkg::SEQ_DECODE;
            end
            lmfb_pkg::SEQ_DECODE: begin
                if (out_room && mod_last) n_state = lmfb_pkg::SEQ_SCAN;
            end
            lmfb_pkg::SEQ_SCAN: begin
                if (out_room && mod_last) n_state = lmfb_pkg::SEQ_BRIGHT;
            end
            lmfb_pkg::SEQ_BRIGHT: begin
                if (out_room && mod_last) n_state = lmfb_pkg::SEQ_ROWS;
            end
            lmfb_pkg::SEQ_ROWS: begin
                if (out_room && mod_last && row_last) begin
                    n_state = r_is_init ? lmfb_pkg::SEQ_WAKE : lmfb_pkg::SEQ_IDLE;
                end
            end
            lmfb_pkg::SEQ_WAKE: begin
                if (out_room && mod_last) n_state = lmfb_pkg::SEQ_IDLE;
            end
            default: n_state = lmfb_pkg::SEQ_IDLE;
        endcase
    end

    // sequencer outputs: request pop, result push, buffer actions
    always_comb begin
        o_req_pop           = 1'b0;
        out_push            = 1'b0;
        exec                = 1'b0;
        clr_all             = 1'b0;
        out_res.spi_word    = '0;
        out_res.is_spi_word = 1'b0;
        out_res.read_data   = '0;
        out_res.error       = 1'b0;
        out_res.last        = 1'b0;
        unique case (r_state)
            lmfb_pkg::SEQ_IDLE: begin
                if (i_req_valid && out_room) begin
                    o_req_pop = 1'b1;
                    if (i_req.op != lmfb_pkg::CMD_REFRESH && i_req.op != lmfb_pkg::CMD_INIT) begin
                        out_push     = 1'b1;
                        exec         = 1'b1;
                        out_res.last = 1'b1;
                        clr_all      = (i_req.op == lmfb_pkg::CMD_CLEAR) ||
                                       (i_req.op == lmfb_pkg::CMD_SCROLL && i_req.sh_clr);
                        if (i_req.op == lmfb_pkg::CMD_READ && i_req.row_ok) begin
                            out_res.read_data = rd_row;
                        end
                        out_res.error = !i_req.row_ok && (i_req.op == lmfb_pkg::CMD_WRITE ||
                                        i_req.op == lmfb_pkg::CMD_READ ||
                                        i_req.op == lmfb_pkg::CMD_SETBIT);
                    end
                end
            end
            lmfb_pkg::SEQ_SHUT: begin
                out_push            = out_room;
                out_res.is_spi_word = 1'b1;
                out_res.spi_word    = lmfb_pkg::WORD_SHUTDOWN;
                // buffer clears once the shutdown words are out
                clr_all             = out_room && mod_last;
            end
            lmfb_pkg::SEQ_DECODE: begin
                out_push            = out_room;
                out_res.is_spi_word = 1'b1;
                out_res.spi_word    = lmfb_pkg::WORD_DECODE_OFF;
            end
            lmfb_pkg::SEQ_SCAN: begin
                out_push            = out_room;
                out_res.is_spi_word = 1'b1;
                out_res.spi_word    = lmfb_pkg::WORD_SCAN_ALL;
            end
            lmfb_pkg::SEQ_BRIGHT: begin
                out_push            = out_room;
                out_res.is_spi_word = 1'b1;
                out_res.spi_word    = lmfb_pkg::WORD_BRIGHT_BASE |
                                      lmfb_pkg::WORD_W'(r_brightness);
            end
            lmfb_pkg::SEQ_ROWS: begin
                out_push            = out_room;
                out_res.is_spi_word = 1'b1;
                out_res.spi_word    = row_word;
                out_res.last        = !r_is_init && mod_last && row_last;
            end
            lmfb_pkg::SEQ_WAKE: begin
                out_push            = out_room;
                out_res.is_spi_word = 1'b1;
                out_res.spi_word    = lmfb_pkg::WORD_WAKE;
                out_res.last        = mod_last;
            end
            default: begin
                out_push = 1'b0;
            end
        endcase
    end

    // state and word counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lmfb_pkg::SEQ_IDLE;
            r_row_cnt <= '0;
            r_mod_cnt <= '0;
            r_is_init <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lmfb_pkg::SEQ_IDLE) begin
                r_row_cnt <= '0;
                r_mod_cnt <= '0;
                r_is_init <= i_req.op == lmfb_pkg::CMD_INIT;
            end else if (out_room) begin
                r_mod_cnt <= mod_last ? '0 : r_mod_cnt + 1'b1;
                if (r_state == lmfb_pkg::SEQ_ROWS && mod_last) begin
                    r_row_cnt <= row_last ? '0 : r_row_cnt + 1'b1;
                end
            end
        end
    end

    // frame buffer update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            for (int r = 0; r < ROWS; r++) begin
                r_frame[r] <= '0;
            end
        end else if (exec) begin
            unique case (i_req.op)
                lmfb_pkg::CMD_WRITE: begin
                    if (i_req.row_ok) r_frame[i_req.row[ROW_CW-1:0]] <= i_req.row_data;
                end
                lmfb_pkg::CMD_SETBIT: begin
                    if (i_req.row_ok) begin
                        r_frame[i_req.row[ROW_CW-1:0]][i_req.col] <= i_req.bit_value;
                    end
                end
                lmfb_pkg::CMD_SCROLL: begin
                    for (int r = 0; r < ROWS; r++) begin
                        r_frame[r] <= i_req.sh_neg ? (r_frame[r] >> i_req.sh_amt)
                                                   : (r_frame[r] << i_req.sh_amt);
                    end
                end
                default: begin
                    r_frame[0] <= r_frame[0];
                end
            endcase
        end
    end

    lmfb_fifo #(
        .WIDTH ($bits(lmfb_pkg::t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_res),
        .i_pop   (i_res_pop),
        .o_rdata (o_res),
        .o_full  (out_full),
        .o_empty (o_res_empty)
    );

endmodule

`default_nettype wire

/* src/led_matrix_frame_buffer_refresh.sv */
// Frame buffer and word sequencer for a chain of cascaded 8x8 LED driver chips.
// Throughput: buffer commands 1 per cycle while the result queue has room; a refresh
// holds the back end while it sends the row words, an init while it sends the
// shutdown, decode, scan, brightness, row and wake words, one word per cycle as
// pops allow. Synchronous active-low reset clears the buffer and queues and sets
// brightness to 15; no clearing pass.
`default_nettype none

module led_matrix_frame_buffer_refresh #(
    parameter int ROWS    = lmfb_pkg::ROWS_DEF,
    parameter int MODULES = lmfb_pkg::MODULES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_wr_en,
    input  wire logic        [lmfb_pkg::BRIGHT_W-1:0] i_cfg_wr_data,
    // request side
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic        [lmfb_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic        [lmfb_pkg::ROW_W-1:0]   i_row,
    input  wire logic        [lmfb_pkg::COL_W-1:0]   i_col,
    input  wire logic                               i_bit_value,
    input  wire logic signed [lmfb_pkg::SHIFT_W-1:0] i_shift_amount,
    input  wire logic        [lmfb_pkg::COLS-1:0]    i_row_data,
    // result side
    output logic                                    empty,
    input  wire logic                               pop,
    output logic             [lmfb_pkg::WORD_W-1:0]  o_spi_word,
    output logic                                    o_is_spi_word,
    output logic             [lmfb_pkg::COLS-1:0]    o_read_data,
    output logic                                    o_error,
    output logic                                    o_last
);

    lmfb_pkg::t_req req;
    logic           req_valid;
    logic           req_pop;
    lmfb_pkg::t_res res;

    lmfb_front #(
        .ROWS (ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_cmd          (i_cmd),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_bit_value    (i_bit_value),
        .i_shift_amount (i_shift_amount),
        .i_row_data     (i_row_data),
        .o_full         (full),
        .i_req_pop      (req_pop),
        .o_req          (req),
        .o_req_valid    (req_valid)
    );

    lmfb_back #(
        .ROWS    (ROWS),
        .MODULES (MODULES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req),
        .i_req_valid   (req_valid),
        .o_req_pop     (req_pop),
        .i_res_pop     (pop),
        .o_res         (res),
        .o_res_empty   (empty)
    );

    // result fields
    assign o_spi_word    = res.spi_word;
    assign o_is_spi_word = res.is_spi_word;
    assign o_read_data   = res.read_data;
    assign o_error       = res.error;
    assign o_last        = res.last;

endmodule

`default_nettype wire

/* src/lmfb_checker.sv */
// Port-level checker for the LED matrix frame buffer, bound to the top level.
// Depends on led_matrix_frame_buffer_refresh_defines.svh.
`default_nettype none
`include "led_matrix_frame_buffer_refresh_defines.svh"

module lmfb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [15:0] o_spi_word,
    input wire logic        o_is_spi_word,
    input wire logic [31:0] o_read_data,
    input wire logic        o_error,
    input wire logic        o_last
);

    // both queues come out of reset drained
    `LMFB_ASSERT_ALWAYS(a_rst_drained, !i_rst_n |=> empty && !full, "queues not empty after reset")

    // driver words never carry read data or an error
    `LMFB_ASSERT_CLK(a_word_clean, !empty && o_is_spi_word |-> o_read_data == 32'd0 && !o_error, "driver word carries buffer fields")

    // buffer command results are single and carry no word
    `LMFB_ASSERT_CLK(a_cmd_single, !empty && !o_is_spi_word |-> o_last && o_spi_word == 16'd0, "buffer result malformed")

    // a waiting result that is not taken holds
    `LMFB_ASSERT_CLK(a_hold, !empty && !pop |=> !empty && $stable(o_spi_word) && $stable(o_last), "waiting result changed")

endmodule

bind led_matrix_frame_buffer_refresh lmfb_checker u_lmfb_checker (.*);

`default_nettype wire
